/* rtl/bc1_block_decompressor_assert.svh */
// ----------------------------------------------------------------------------
// BC1 decompressor assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// The clock is clk and the reset arst_n in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef BC1_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define BC1_BLOCK_DECOMPRESSOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BC1_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bc1: implication check failed");

// next-cycle implication
`define BC1_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bc1: next-cycle check failed");

`else

`define BC1_ASSERT_IMPL(name, ante, cons)
`define BC1_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* rtl/bc1_pkg.sv */
// ----------------------------------------------------------------------------
// bc1_pkg
// Shared types and constants of the BC1 block decompressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bc1_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 13'd256;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	// floor(n/3) == (n*683) >> 11 for n < 2048
	localparam logic [9:0] RECIP3       = 10'd683;
	localparam int         RECIP3_SHIFT = 11;

	localparam logic [2:0] TILE_SIDE   = 3'd4;
	localparam int         QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] image_width;
		logic [CFG_DATA_W-1:0] image_height;
	} bc1_cfg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} bc1_rgba_t;

	// one decoded tile as it sits in the queue
	typedef struct packed {
		bc1_rgba_t [3:0] pal;
		logic [31:0]     codes;
		logic [2:0]      ncols;   // visible columns, 1..4
		logic [2:0]      nrows;   // visible rows, 1..4
	} bc1_tile_t;

endpackage

`default_nettype wire

/* rtl/bc1_queue.sv */
// ----------------------------------------------------------------------------
// bc1_queue
// Short FIFO between the tile front end and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bc1_block_decompressor_assert.svh"

module bc1_queue
	import bc1_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic     [W-1:0]  rdata,
	output logic              full,
	output logic              empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`BC1_ASSERT_IMPL(a_no_overflow, full, !push)
	`BC1_ASSERT_IMPL(a_no_underflow, empty, !pop)

endmodule

`default_nettype wire

/* rtl/bc1_front.sv */
// ----------------------------------------------------------------------------
// bc1_front
// Accepts blocks, tracks tile position, clips and builds the palette.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bc1_block_decompressor_assert.svh"

module bc1_front
	import bc1_pkg::*;
#(
	parameter int MAX_SIDE = 4096,
	parameter int TILE_W   = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bc1_cfg_t          cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [15:0]       endpoint_a,
	input  wire logic [15:0]       endpoint_b,
	input  wire logic [31:0]       code_bits,
	input  wire logic              q_full,
	output logic                   push,
	output bc1_tile_t              tile,
	output logic      [TILE_W-1:0] tile_col,
	output logic      [TILE_W-1:0] tile_row
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int XW = TILE_W + 2;

	// clamped dimensions and tile counts
	logic [SW+CFG_DATA_W-1:0] w_ext, h_ext;
	logic [SW-1:0]            w, h;
	logic [SW:0]              wp3, hp3;
	logic [SW-2:0]            tiles_x, tiles_y;

	always_comb begin
		w_ext = {SW'(0), cfg.image_width};
		h_ext = {SW'(0), cfg.image_height};
		if (cfg.image_width == '0) begin
			w = SW'(1);
		end else if (cfg.image_width > MAX_SIDE) begin
			w = SW'(MAX_SIDE);
		end else begin
			w = w_ext[SW-1:0];
		end
		if (cfg.image_height == '0) begin
			h = SW'(1);
		end else if (cfg.image_height > MAX_SIDE) begin
			h = SW'(MAX_SIDE);
		end else begin
			h = h_ext[SW-1:0];
		end
		wp3     = {1'b0, w} + (SW+1)'(3);
		hp3     = {1'b0, h} + (SW+1)'(3);
		tiles_x = wp3[SW:2];
		tiles_y = hp3[SW:2];
	end

	// tile position and visible extent of the block about to be accepted
	logic [TILE_W-1:0]    col_q, row_q;
	logic [TILE_W:0]      col_nx, row_nx;
	logic [XW-1:0]        x0, y0;
	logic [SW+XW-1:0]     x0_ext, y0_ext;
	logic [SW-1:0]        remx, remy;
	logic [2:0]           ncols, nrows;

	always_comb begin
		col_nx = {1'b0, col_q} + (TILE_W+1)'(1);
		row_nx = {1'b0, row_q} + (TILE_W+1)'(1);
		x0     = {col_q, 2'b00};
		y0     = {row_q, 2'b00};
		x0_ext = {SW'(0), x0};
		y0_ext = {SW'(0), y0};
		remx   = w - x0_ext[SW-1:0];
		remy   = h - y0_ext[SW-1:0];
		if (x0_ext >= (SW+XW)'(w)) begin
			ncols = 3'd0;
		end else if (remx >= SW'(TILE_SIDE)) begin
			ncols = TILE_SIDE;
		end else begin
			ncols = remx[2:0];
		end
		if (y0_ext >= (SW+XW)'(h)) begin
			nrows = 3'd0;
		end else if (remy >= SW'(TILE_SIDE)) begin
			nrows = TILE_SIDE;
		end else begin
			nrows = remy[2:0];
		end
	end

	// stage 1
	logic              valid_s1;
	logic [15:0]       ea_s1, eb_s1;
	logic [31:0]       codes_s1;
	logic [TILE_W-1:0] col_s1, row_s1;
	logic [2:0]        ncols_s1, nrows_s1;
	logic              clipped_s1;
	logic              adv;
	logic              accept;

	assign clipped_s1 = (ncols_s1 == 3'd0) || (nrows_s1 == 3'd0);
	assign adv        = !valid_s1 || clipped_s1 || !q_full;
	assign in_stall   = !adv;
	assign accept     = in_valid && adv;
	assign push       = valid_s1 && !clipped_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				if (col_nx >= (TILE_W+1)'(tiles_x)) begin
					col_q <= '0;
					if (row_nx >= (TILE_W+1)'(tiles_y)) begin
						row_q <= '0;
					end else begin
						row_q <= row_nx[TILE_W-1:0];
					end
				end else begin
					col_q <= col_nx[TILE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ea_s1    <= endpoint_a;
			eb_s1    <= endpoint_b;
			codes_s1 <= code_bits;
			col_s1   <= col_q;
			row_s1   <= row_q;
			ncols_s1 <= ncols;
			nrows_s1 <= nrows;
		end
	end

	// palette
	function automatic logic [7:0] div3(input logic [9:0] n);
		logic [19:0] prod;
		logic [19:0] sh;
		prod = 20'(n) * 20'(RECIP3);
		sh   = prod >> RECIP3_SHIFT;
		return sh[7:0];
	endfunction

	logic [7:0] c0 [3];
	logic [7:0] c1 [3];
	logic [7:0] e2 [3];
	logic [7:0] e3 [3];
	logic [9:0] n2 [3];
	logic [9:0] n3 [3];
	logic [8:0] sum [3];
	logic       four_color;

	always_comb begin
		c0[0] = {ea_s1[15:11], ea_s1[15:13]};
		c0[1] = {ea_s1[10:5], ea_s1[10:9]};
		c0[2] = {ea_s1[4:0], ea_s1[4:2]};
		c1[0] = {eb_s1[15:11], eb_s1[15:13]};
		c1[1] = {eb_s1[10:5], eb_s1[10:9]};
		c1[2] = {eb_s1[4:0], eb_s1[4:2]};
		four_color = (ea_s1 > eb_s1);
		for (int ch = 0; ch < 3; ch++) begin
			n2[ch]  = {1'b0, c0[ch], 1'b0} + 10'(c1[ch]) + 10'd1;
			n3[ch]  = {1'b0, c1[ch], 1'b0} + 10'(c0[ch]) + 10'd1;
			sum[ch] = 9'(c0[ch]) + 9'(c1[ch]);
			if (four_color) begin
				e2[ch] = div3(n2[ch]);
				e3[ch] = div3(n3[ch]);
			end else begin
				e2[ch] = sum[ch][8:1];
				e3[ch] = 8'd0;
			end
		end
		tile.pal[0] = '{r: c0[0], g: c0[1], b: c0[2], a: ALPHA_OPAQUE};
		tile.pal[1] = '{r: c1[0], g: c1[1], b: c1[2], a: ALPHA_OPAQUE};
		tile.pal[2] = '{r: e2[0], g: e2[1], b: e2[2], a: ALPHA_OPAQUE};
		tile.pal[3] = '{r: e3[0], g: e3[1], b: e3[2],
			a: (four_color ? ALPHA_OPAQUE : ALPHA_CLEAR)};
		tile.codes  = codes_s1;
		tile.ncols  = ncols_s1;
		tile.nrows  = nrows_s1;
	end

	assign tile_col = col_s1;
	assign tile_row = row_s1;

	`BC1_ASSERT_IMPL(a_stall_only_when_held, !valid_s1, !in_stall)
	`BC1_ASSERT_IMPL(a_clipped_not_queued, valid_s1 && clipped_s1, !push)

endmodule

`default_nettype wire

/* rtl/bc1_back.sv */
// ----------------------------------------------------------------------------
// bc1_back
// Walks the visible pixels of the queued tile, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bc1_block_decompressor_assert.svh"

module bc1_back
	import bc1_pkg::*;
#(
	parameter int TILE_W = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bc1_tile_t         head,
	input  wire logic [TILE_W-1:0] head_col,
	input  wire logic [TILE_W-1:0] head_row,
	input  wire logic              q_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [11:0]       pixel_x,
	output logic      [11:0]       pixel_y,
	output logic      [7:0]        red,
	output logic      [7:0]        green,
	output logic      [7:0]        blue,
	output logic      [7:0]        alpha,
	output logic                   last_of_block
);

	localparam int XW = TILE_W + 2;

	logic [1:0]       c_q, r_q;
	logic [1:0]       last_c, last_r;
	logic             at_col_end, at_last;
	logic             adv, load;
	logic [4:0]       code_lsb;
	logic [1:0]       code;
	bc1_rgba_t        px;
	logic [XW+11:0]   x_ext, y_ext;

	assign last_c     = 2'(head.ncols - 3'd1);
	assign last_r     = 2'(head.nrows - 3'd1);
	assign at_col_end = (c_q == last_c);
	assign at_last    = at_col_end && (r_q == last_r);
	assign adv        = !out_valid || !out_stall;
	assign load       = adv && !q_empty;
	assign pop        = load && at_last;

	assign code_lsb = {r_q, c_q, 1'b0};
	assign code     = head.codes[code_lsb +: 2];
	assign px       = head.pal[code];
	assign x_ext    = {12'd0, head_col, c_q};
	assign y_ext    = {12'd0, head_row, r_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			c_q       <= '0;
			r_q       <= '0;
		end else if (adv) begin
			out_valid <= !q_empty;
			if (load) begin
				if (at_last) begin
					c_q <= '0;
					r_q <= '0;
				end else if (at_col_end) begin
					c_q <= '0;
					r_q <= r_q + 2'd1;
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_x       <= x_ext[11:0];
			pixel_y       <= y_ext[11:0];
			red           <= px.r;
			green         <= px.g;
			blue          <= px.b;
			alpha         <= px.a;
			last_of_block <= at_last;
		end
	end

	`BC1_ASSERT_IMPL(a_head_extent, !q_empty,
		(head.ncols != 3'd0) && (head.nrows != 3'd0) &&
		(head.ncols <= TILE_SIDE) && (head.nrows <= TILE_SIDE))

endmodule

`default_nettype wire

/* rtl/bc1_block_decompressor.sv */
// ----------------------------------------------------------------------------
// bc1_block_decompressor
// BC1 (DXT1) block decoder: one 4x4 block in, its visible RGBA pixels out.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | transfer when
//  --------+------------------------------------------------+-------------------
//  in      | in_valid, in_stall, endpoint_a/b, code_bits    | valid && !stall
//  out     | out_valid, out_stall, pixel_x/y, red, green,   | valid && !stall
//          | blue, alpha, last_of_block                     |
//  cfg     | cfg_write, cfg_index, cfg_data                 | cfg_write high
//
// Pixels: the back end emits one pixel per cycle while a tile is queued and
// the output is not stalled, and walks only the visible pixels of a clipped
// tile. A tile with no visible pixel is dropped by the front end and never
// queued. A block passes from the transfer into stage 1, then the queue,
// then the output register.
// Reset: clears position, handshake state and sets both sides to 256; no
// memory sweep. Stalls: the front end keeps taking blocks while the two-entry
// queue has room, independent of a stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bc1_block_decompressor
	import bc1_pkg::*;
#(
	parameter int MAX_SIDE = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// block input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [15:0]           endpoint_a,
	input  wire logic [15:0]           endpoint_b,
	input  wire logic [31:0]           code_bits,
	// pixel output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [11:0]           pixel_x,
	output logic      [11:0]           pixel_y,
	output logic      [7:0]            red,
	output logic      [7:0]            green,
	output logic      [7:0]            blue,
	output logic      [7:0]            alpha,
	output logic                       last_of_block
);

	// tile index width: enough for the tile count along the longest side
	localparam int TILES_MAX = (MAX_SIDE + 3) / 4;
	localparam int TILE_W    = (TILES_MAX > 1) ? $clog2(TILES_MAX) : 1;
	localparam int QW        = $bits(bc1_tile_t) + 2 * TILE_W;

	// configuration registers: the user must write them only while idle; the block does not enforce it
	bc1_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= SIDE_RESET;
			cfg_q.image_height <= SIDE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				default: ; // unmapped index: write is dropped
			endcase
		end
	end

	// front end: position tracking, clipping, palette
	logic              f_push;
	bc1_tile_t         f_tile;
	logic [TILE_W-1:0] f_col, f_row;
	logic              q_full, q_empty, q_pop;
	logic [QW-1:0]     q_wdata, q_rdata;

	bc1_front #(
		.MAX_SIDE (MAX_SIDE),
		.TILE_W   (TILE_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.endpoint_a (endpoint_a),
		.endpoint_b (endpoint_b),
		.code_bits  (code_bits),
		.q_full     (q_full),
		.push       (f_push),
		.tile       (f_tile),
		.tile_col   (f_col),
		.tile_row   (f_row)
	);

	// decoupling queue, tile plus its position
	assign q_wdata = {f_tile, f_col, f_row};

	bc1_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bc1_tile_t         b_tile;
	logic [TILE_W-1:0] b_col, b_row;

	assign {b_tile, b_col, b_row} = q_rdata;

	// back end: per-pixel walk into the output register
	bc1_back #(
		.TILE_W (TILE_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (b_tile),
		.head_col      (b_col),
		.head_row      (b_row),
		.q_empty       (q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.last_of_block (last_of_block)
	);

endmodule

`default_nettype wire
